// ----- design/card_id_whitelist_table_macros.svh -----
// ----------------------------------------------------------------------------
// Card ID whitelist table assertion macros
// Shared assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef CARD_ID_WHITELIST_TABLE_MACROS_SVH
`define CARD_ID_WHITELIST_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define CWT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled in reset.
`define CWT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/cwt_pkg.sv -----
// ----------------------------------------------------------------------------
// Card ID whitelist table package
// Shared constants, command and status codes, and controller interface types.
// ----------------------------------------------------------------------------
package cwt_pkg;

  localparam int SLOTS_DEF = 128;
  localparam int CMD_W     = 2;
  localparam int KEY_W     = 32;
  localparam int ST_W      = 2;
  localparam int SLOT_W    = 7;

  localparam logic [KEY_W-1:0] MARK_EMPTY = 32'h3D3D_3D3D;
  localparam logic [KEY_W-1:0] MARK_TOMB  = 32'h2D2D_2D2D;

  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_AUTH    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REVOKE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CONFIRM = 2'd3;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_MISS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic start;
    logic cnt_inc;
    logic rd_en;
    logic sweep_wr;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic cnt_last;
  } dp_stat_t;

endpackage

// ----- design/cwt_dpath.sv -----
// ----------------------------------------------------------------------------
// Card ID whitelist table datapath
// Slot memory, scan counter, first-match trackers and the result register.
// ----------------------------------------------------------------------------
module cwt_dpath #(
  parameter int SLOTS = cwt_pkg::SLOTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cwt_pkg::ctl_cmd_t         ctl,
  output cwt_pkg::dp_stat_t         stat,
  input  logic [cwt_pkg::CMD_W-1:0] in_cmd,
  input  logic [cwt_pkg::KEY_W-1:0] in_key,
  output logic [cwt_pkg::ST_W-1:0]  res_status,
  output logic [cwt_pkg::SLOT_W-1:0] res_slot
);

  localparam int AW = $clog2(SLOTS);

  logic [cwt_pkg::KEY_W-1:0] mem [SLOTS];

  logic [AW-1:0]             cnt_r;
  logic [cwt_pkg::CMD_W-1:0] cmd_r;
  logic [cwt_pkg::KEY_W-1:0] key_r;
  logic [cwt_pkg::KEY_W-1:0] rd_data_r;
  logic [AW-1:0]             rd_idx_r;
  logic                      rd_vld_r;
  logic                      hit_r, emp_r, tmb_r;
  logic [AW-1:0]             hit_idx_r, emp_idx_r, tmb_idx_r;
  logic [cwt_pkg::ST_W-1:0]  st_r;
  logic [cwt_pkg::SLOT_W-1:0] slot_r;

  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [cwt_pkg::KEY_W-1:0] wr_data;
  logic                      dec_wr;
  logic [AW-1:0]             dec_idx;
  logic [cwt_pkg::KEY_W-1:0] dec_data;
  logic [cwt_pkg::ST_W-1:0]  dec_st;
  logic                      dec_slot_vld;

  assign stat.cnt_last = (cnt_r == AW'(SLOTS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ctl.start) begin
        cnt_r <= '0;
      end else if (ctl.cnt_inc) begin
        cnt_r <= cnt_r + AW'(1);
      end
      rd_vld_r <= ctl.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[cnt_r];
    end
    rd_idx_r <= cnt_r;
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      cmd_r <= in_cmd;
      key_r <= in_key;
      hit_r <= 1'b0;
      emp_r <= 1'b0;
      tmb_r <= 1'b0;
    end else if (rd_vld_r) begin
      if (!hit_r && rd_data_r == key_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= rd_idx_r;
      end
      if (!emp_r && rd_data_r == cwt_pkg::MARK_EMPTY) begin
        emp_r     <= 1'b1;
        emp_idx_r <= rd_idx_r;
      end
      if (!tmb_r && rd_data_r == cwt_pkg::MARK_TOMB) begin
        tmb_r     <= 1'b1;
        tmb_idx_r <= rd_idx_r;
      end
    end
  end

  always_comb begin
    dec_wr       = 1'b0;
    dec_idx      = hit_idx_r;
    dec_data     = key_r;
    dec_st       = cwt_pkg::ST_OK;
    dec_slot_vld = 1'b0;
    unique case (cmd_r)
      cwt_pkg::CMD_CLEAR: begin
        dec_st = cwt_pkg::ST_OK;
      end
      cwt_pkg::CMD_AUTH: begin
        priority if (hit_r) begin
          dec_st       = cwt_pkg::ST_MISS;
          dec_slot_vld = 1'b1;
        end else if (emp_r) begin
          dec_wr       = 1'b1;
          dec_idx      = emp_idx_r;
          dec_slot_vld = 1'b1;
        end else if (tmb_r) begin
          dec_wr       = 1'b1;
          dec_idx      = tmb_idx_r;
          dec_slot_vld = 1'b1;
        end else begin
          dec_st = cwt_pkg::ST_FULL;
        end
      end
      cwt_pkg::CMD_REVOKE: begin
        if (hit_r) begin
          dec_wr       = 1'b1;
          dec_data     = cwt_pkg::MARK_TOMB;
          dec_slot_vld = 1'b1;
        end else begin
          dec_st = cwt_pkg::ST_MISS;
        end
      end
      cwt_pkg::CMD_CONFIRM: begin
        if (hit_r) begin
          dec_slot_vld = 1'b1;
        end else begin
          dec_st = cwt_pkg::ST_MISS;
        end
      end
      default: begin
        dec_st = cwt_pkg::ST_MISS;
      end
    endcase
  end

  always_comb begin
    priority if (ctl.sweep_wr) begin
      wr_en   = 1'b1;
      wr_addr = cnt_r;
      wr_data = cwt_pkg::MARK_EMPTY;
    end else if (ctl.commit && dec_wr) begin
      wr_en   = 1'b1;
      wr_addr = dec_idx;
      wr_data = dec_data;
    end else begin
      wr_en   = 1'b0;
      wr_addr = dec_idx;
      wr_data = dec_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      st_r   <= dec_st;
      slot_r <= dec_slot_vld ? cwt_pkg::SLOT_W'(dec_idx) : '0;
    end
  end

  assign res_status = st_r;
  assign res_slot   = slot_r;

endmodule

// ----- design/cwt_ctrl.sv -----
// ----------------------------------------------------------------------------
// Card ID whitelist table controller
// Sequences the clearing sweep, the slot scan and the result handoff.
// ----------------------------------------------------------------------------
module cwt_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [cwt_pkg::CMD_W-1:0] in_cmd,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output cwt_pkg::ctl_cmd_t         ctl,
  input  cwt_pkg::dp_stat_t         stat
);

  localparam logic [2:0] S_INIT    = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_SCAN    = 3'd2;
  localparam logic [2:0] S_DRAIN   = 3'd3;
  localparam logic [2:0] S_CLEAR   = 3'd4;
  localparam logic [2:0] S_RESOLVE = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      S_INIT: begin
        ctl.sweep_wr = 1'b1;
        ctl.cnt_inc  = 1'b1;
        if (stat.cnt_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          ctl.start = 1'b1;
          state_nxt = (in_cmd == cwt_pkg::CMD_CLEAR) ? S_CLEAR : S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.rd_en   = 1'b1;
        ctl.cnt_inc = 1'b1;
        if (stat.cnt_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_RESOLVE;
      end
      S_CLEAR: begin
        ctl.sweep_wr = 1'b1;
        ctl.cnt_inc  = 1'b1;
        if (stat.cnt_last) begin
          state_nxt = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        if (out_free) begin
          ctl.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- design/card_id_whitelist_table.sv -----
// ----------------------------------------------------------------------------
// Card ID whitelist table
// Slot table of card IDs with authorize, revoke, confirm and clear commands.
// ----------------------------------------------------------------------------
// The input channel carries one command word: in_tuser holds the command and
// in_tdata the card ID. The result channel returns one word per command with
// the status in out_tuser and the slot number in out_tdata.
// Every command other than clear reads all SLOTS slots from one memory read
// port, one slot per cycle, and passes a drain state and a resolve state
// before the result is registered and out_tvalid rises. Clear writes the
// empty marker into every slot, one per cycle, then passes the resolve state.
// in_tready rises with out_tvalid, so the next command can be accepted while
// that result is shown. After reset the block runs the same clearing sweep
// over all SLOTS slots with in_tready low, then accepts commands.
// A new command is accepted while a result still waits in the output
// register. If the receiver holds out_tready low, the finished next result
// waits inside the block and in_tready stays low until the register frees.
// ----------------------------------------------------------------------------
module card_id_whitelist_table #(
  parameter int SLOTS = cwt_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // card_id[31:0]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // slot[6:0], zero[7]
  output logic [1:0]  out_tuser   // status[1:0]
);

  cwt_pkg::ctl_cmd_t            ctl;
  cwt_pkg::dp_stat_t            stat;
  logic [cwt_pkg::ST_W-1:0]     res_status;
  logic [cwt_pkg::SLOT_W-1:0]   res_slot;

  cwt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctl        (ctl),
    .stat       (stat)
  );

  cwt_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .stat       (stat),
    .in_cmd     (in_tuser),
    .in_key     (in_tdata),
    .res_status (res_status),
    .res_slot   (res_slot)
  );

  assign out_tdata = {1'b0, res_slot};
  assign out_tuser = res_status;

endmodule

// ----- design/cwt_checker.sv -----
// ----------------------------------------------------------------------------
// Card ID whitelist table port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`include "card_id_whitelist_table_macros.svh"

module cwt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic [1:0]  out_tuser
);

  `CWT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "Result word changed while stalled")
  `CWT_ASSERT_NOW(a_status_code, out_tvalid, out_tuser == cwt_pkg::ST_OK || out_tuser == cwt_pkg::ST_MISS || out_tuser == cwt_pkg::ST_FULL, "Undefined status code")
  `CWT_ASSERT_NOW(a_full_slot, out_tvalid && out_tuser == cwt_pkg::ST_FULL, out_tdata == 8'd0, "Full status with nonzero slot")
  `CWT_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "Command accepted while a scan runs")

endmodule

bind card_id_whitelist_table cwt_checker u_cwt_checker (.*);

// ----- tb/tb_card_id_whitelist_table.sv -----
// ----------------------------------------------------------------------------
// Card ID whitelist table testbench
// Drives authorize, revoke, confirm and clear commands into the table, first
// from a short directed list and then as random fill and mixed sequences, and
// checks each result word against the directed row's word or a slot-table
// predictor. Both channels idle at random, the receiver once holds off long
// enough to stall the input, and a watchdog ends a run that stops moving.
// ----------------------------------------------------------------------------
module tb_card_id_whitelist_table;
  timeunit 1ns;
  timeprecision 1ps;

  import cwt_pkg::*;

  localparam int SLOTS          = SLOTS_DEF;
  localparam int POOL_SIZE      = 160;
  localparam int FILL_ITEMS     = 140;
  localparam int MIXED_ITEMS    = 220;
  localparam int HOLD_AT        = 150;
  localparam int HOLD_CYCLES    = 1200;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int TAIL_CYCLES    = 300;
  localparam int N_DIRECTED     = 22;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [SLOT_W-1:0] slot;
  } reply_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [KEY_W-1:0]  key;
    logic              fixed;
    logic [ST_W-1:0]   status;
    logic [SLOT_W-1:0] slot;
  } step_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // card_id[31:0]
  logic [1:0]  in_tuser;   // cmd[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // slot[6:0], zero[7]
  logic [1:0]  out_tuser;  // status[1:0]

  logic [KEY_W-1:0] roster [SLOTS];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  reply_t           pending_replies [$];
  step_row_t        directed_rows [N_DIRECTED];

  int snd_idle_pct;
  int rcv_idle_pct;
  int words_out;
  int mismatches;
  int stall_cycles;
  bit hold_pending;

  card_id_whitelist_table u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void lookup_reply(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k,
                                       output reply_t r);
    int hit_key;
    int hit_empty;
    int hit_tomb;
    hit_key   = -1;
    hit_empty = -1;
    hit_tomb  = -1;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (roster[i] == k) hit_key = i;
      if (roster[i] == MARK_EMPTY) hit_empty = i;
      if (roster[i] == MARK_TOMB) hit_tomb = i;
    end
    r.status = ST_OK;
    r.slot   = '0;
    case (c)
      CMD_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) roster[i] = MARK_EMPTY;
      end
      CMD_AUTH: begin
        if (hit_key >= 0) begin
          r.status = ST_MISS;
          r.slot   = SLOT_W'(hit_key);
        end else if (hit_empty >= 0) begin
          roster[hit_empty] = k;
          r.slot = SLOT_W'(hit_empty);
        end else if (hit_tomb >= 0) begin
          roster[hit_tomb] = k;
          r.slot = SLOT_W'(hit_tomb);
        end else begin
          r.status = ST_FULL;
        end
      end
      CMD_REVOKE: begin
        if (hit_key >= 0) begin
          roster[hit_key] = MARK_TOMB;
          r.slot = SLOT_W'(hit_key);
        end else begin
          r.status = ST_MISS;
        end
      end
      default: begin
        if (hit_key >= 0) r.slot = SLOT_W'(hit_key);
        else r.status = ST_MISS;
      end
    endcase
  endfunction

  task automatic push_command(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k,
                              input logic fixed, input reply_t typed);
    reply_t guess;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = c;
    in_tdata  = k;
    do @(posedge clk); while (!in_tready);
    lookup_reply(c, k, guess);
    pending_replies.push_back(fixed ? typed : guess);
    @(negedge clk);
  endtask

  task automatic drain_replies();
    in_tvalid = 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase();
    reply_t     none;
    logic [1:0] c;
    logic [31:0] k;
    int         r;
    none = '0;
    drain_replies();
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    push_command(CMD_CLEAR, $urandom, 1'b0, none);
    for (int i = 0; i < FILL_ITEMS; i++) push_command(CMD_AUTH, key_pool[i], 1'b0, none);
    for (int i = 0; i < MIXED_ITEMS; i++) begin
      r = $urandom_range(99);
      if (r < 2) c = CMD_CLEAR;
      else if (r < 38) c = CMD_AUTH;
      else if (r < 68) c = CMD_REVOKE;
      else c = CMD_CONFIRM;
      r = $urandom_range(99);
      if (r < 85) k = key_pool[$urandom_range(POOL_SIZE - 1)];
      else if (r < 90) k = $urandom_range(1) ? MARK_EMPTY : MARK_TOMB;
      else k = $urandom;
      push_command(c, k, 1'b0, none);
    end
  endtask

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending && words_out >= HOLD_AT) begin
        hold_pending = 1'b0;
        out_tready   = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_tready = ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      words_out++;
      if (pending_replies.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result word: status %0d tdata %0h", out_tuser, out_tdata);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        if (out_tuser !== want.status || out_tdata !== {1'b0, want.slot}) begin
          if (mismatches < 10)
            $display("mismatch: expected status %0d slot %0d, got status %0d tdata %0h",
                     want.status, want.slot, out_tuser, out_tdata);
          mismatches++;
        end
      end
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    reply_t typed;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    snd_idle_pct = 32;
    rcv_idle_pct = 70;
    words_out    = 0;
    mismatches   = 0;
    hold_pending = 1'b1;
    for (int i = 0; i < SLOTS; i++) roster[i] = MARK_EMPTY;
    directed_rows = '{
      '{CMD_CONFIRM, 32'h0000_0000, 1'b1, ST_MISS, 7'd0},
      '{CMD_AUTH,    32'h0000_0000, 1'b1, ST_OK,   7'd0},
      '{CMD_AUTH,    32'hFFFF_FFFF, 1'b1, ST_OK,   7'd1},
      '{CMD_AUTH,    32'h0000_0000, 1'b1, ST_MISS, 7'd0},
      '{CMD_CONFIRM, 32'hFFFF_FFFF, 1'b1, ST_OK,   7'd1},
      '{CMD_REVOKE,  32'h0000_0000, 1'b1, ST_OK,   7'd0},
      '{CMD_REVOKE,  32'h0000_0000, 1'b1, ST_MISS, 7'd0},
      '{CMD_CONFIRM, MARK_TOMB,     1'b1, ST_OK,   7'd0},
      '{CMD_AUTH,    MARK_EMPTY,    1'b1, ST_MISS, 7'd2},
      '{CMD_CONFIRM, MARK_EMPTY,    1'b1, ST_OK,   7'd2},
      '{CMD_AUTH,    32'h1234_5678, 1'b1, ST_OK,   7'd2},
      '{CMD_REVOKE,  MARK_EMPTY,    1'b1, ST_OK,   7'd3},
      '{CMD_REVOKE,  MARK_TOMB,     1'b1, ST_OK,   7'd0},
      '{CMD_AUTH,    MARK_TOMB,     1'b1, ST_MISS, 7'd0},
      '{CMD_CONFIRM, 32'h0000_0001, 1'b1, ST_MISS, 7'd0},
      '{CMD_AUTH,    32'h8000_0000, 1'b1, ST_OK,   7'd4},
      '{CMD_CLEAR,   32'hFFFF_FFFF, 1'b1, ST_OK,   7'd0},
      '{CMD_CONFIRM, 32'hFFFF_FFFF, 1'b1, ST_MISS, 7'd0},
      '{CMD_AUTH,    32'hAAAA_AAAA, 1'b1, ST_OK,   7'd0},
      '{CMD_AUTH,    32'h5555_5555, 1'b1, ST_OK,   7'd1},
      '{CMD_CONFIRM, 32'h5555_5555, 1'b1, ST_OK,   7'd1},
      '{CMD_REVOKE,  32'hAAAA_AAAA, 1'b0, ST_OK,   7'd0}
    };
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      typed.status = directed_rows[i].status;
      typed.slot   = directed_rows[i].slot;
      push_command(directed_rows[i].cmd, directed_rows[i].key, directed_rows[i].fixed, typed);
    end
    run_phase();

    snd_idle_pct = 70;
    rcv_idle_pct = 32;
    run_phase();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    run_phase();

    drain_replies();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
